>>> src/abpe_pkg.sv
// Shared types and constants for the alpha blend pixel engine.
// No dependencies.
package abpe_pkg;

   localparam int NUM_STAGES = 14;
   localparam int DIV_FIRST  = 4;   // first divider stage
   localparam int DIV_BITS   = 8;   // quotient bits, one per stage

   localparam logic [1:0] MODE_COPY   = 2'd0;
   localparam logic [1:0] MODE_BLEND  = 2'd1;
   localparam logic [1:0] MODE_TINT   = 2'd2;
   localparam logic [1:0] MODE_DOUBLE = 2'd3;

   localparam logic [1:0] REG_BLEND_MODE    = 2'd0;
   localparam logic [1:0] REG_CHANNEL_ORDER = 2'd1;
   localparam logic [1:0] REG_TINT_ARGB     = 2'd2;

   // reciprocal of 255, exact for 16-bit dividends with a shift of 23
   localparam logic [15:0] RECIP_255 = 16'h8081;

   typedef struct packed {
      logic [1:0]       mode;
      logic [31:0]      img;
      logic [31:0]      bg;
      logic [7:0]       a;
      logic [7:0]       ta;
      logic [2:0][7:0]  c;     // r, g, b of the image
      logic [2:0][7:0]  tc;    // tint r, g, b
      logic [2:0][7:0]  tmix;
      logic [2:0][15:0] tcta;
      logic [15:0]      p_ata;
      logic [7:0]       m;
      logic [2:0][15:0] cm;
      logic [15:0]      mta;
      logic [8:0]       msum;
      logic [16:0]      den;
      logic [2:0][24:0] rem;
      logic [2:0][7:0]  q;
      logic [7:0]       fa;
      logic [2:0][7:0]  fc;
      logic [31:0]      res;
   } stage_type;

endpackage

>>> src/alpha_blend_pixel_engine_top.sv
// Alpha blend pixel engine, top level: fourteen-stage compositing pipeline
// with a pipelined restoring divider. Depends on abpe_pkg.
//
// channel  | direction | payload
// req_     | in        | tdata[31:0] image_pixel, tdata[63:32] background_pixel
// rsp_     | out       | tdata[31:0] result_pixel
// csr_     | in        | index 0 blend_mode, 1 channel_order, 2 tint_argb
//
// One pixel per clock sustained while rsp_tready holds; the divider takes eight
// one-bit-per-stage stages, with the multiply stages around them.
// Reset (synchronous) clears valid bits and registers; payload is not reset.
// Each stage holds while the stage after it is full and stalled, so a
// bubble anywhere lets a new request in even while rsp_ waits.
module alpha_blend_pixel_engine_top
   import abpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] image_pixel, [63:32] background_pixel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_pixel
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [1:0]  blend_mode_ff;
   logic        channel_order_ff;
   logic [31:0] tint_argb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff    <= MODE_COPY;
         channel_order_ff <= 1'b0;
         tint_argb_ff     <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            REG_BLEND_MODE:    blend_mode_ff    <= csr_wdata[1:0];
            REG_CHANNEL_ORDER: channel_order_ff <= csr_wdata[0];
            REG_TINT_ARGB:     tint_argb_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   stage_type pipe_ff [NUM_STAGES];
   stage_type pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] en;

   // stage moves when empty or when the next one moves
   always_comb begin
      en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_tready;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = pipe_ff[NUM_STAGES-1].res;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // stage 0: unpack, tint mix, alpha product
   always_comb begin
      logic [31:0] img;
      logic [15:0] mix;
      img = req_tdata[31:0];
      pipe_in[0]      = '0;
      pipe_in[0].mode = blend_mode_ff;
      pipe_in[0].img  = img;
      pipe_in[0].bg   = req_tdata[63:32];
      pipe_in[0].ta   = tint_argb_ff[31:24];
      pipe_in[0].tc   = {tint_argb_ff[7:0], tint_argb_ff[15:8], tint_argb_ff[23:16]};
      if (channel_order_ff) begin
         pipe_in[0].a = img[7:0];
         pipe_in[0].c = {img[31:24], img[23:16], img[15:8]};
      end else begin
         pipe_in[0].a = img[31:24];
         pipe_in[0].c = {img[23:16], img[15:8], img[7:0]};
      end
      pipe_in[0].p_ata = 16'(pipe_in[0].a) * 16'(pipe_in[0].ta);
      for (int i = 0; i < 3; i++) begin
         mix = 16'(pipe_in[0].c[i]) * 16'(8'd255 - pipe_in[0].ta)
             + 16'(pipe_in[0].tc[i]) * 16'(pipe_in[0].ta);
         pipe_in[0].tmix[i] = mix[15:8];
         pipe_in[0].tcta[i] = 16'(pipe_in[0].tc[i]) * 16'(pipe_in[0].ta);
      end
   end

   // stage 1: merged alpha m = a + ta - a*ta/255
   always_comb begin
      logic [31:0] recip;
      recip = 32'(pipe_ff[0].p_ata) * 32'(RECIP_255);
      pipe_in[1]   = pipe_ff[0];
      pipe_in[1].m = 8'(9'(pipe_ff[0].a) + 9'(pipe_ff[0].ta) - 9'(recip[30:23]));
   end

   // stage 2: products with m
   always_comb begin
      pipe_in[2]      = pipe_ff[1];
      pipe_in[2].mta  = 16'(pipe_ff[1].m) * 16'(pipe_ff[1].ta);
      pipe_in[2].msum = 9'(pipe_ff[1].m) + 9'(pipe_ff[1].ta);
      for (int i = 0; i < 3; i++) begin
         pipe_in[2].cm[i] = 16'(pipe_ff[1].c[i]) * 16'(pipe_ff[1].m);
      end
   end

   // stage 3: numerators and divisor
   always_comb begin
      pipe_in[3]     = pipe_ff[2];
      pipe_in[3].den = 17'(17'(pipe_ff[2].msum) * 17'd255) - 17'(pipe_ff[2].mta);
      for (int i = 0; i < 3; i++) begin
         pipe_in[3].rem[i] = 25'(pipe_ff[2].cm[i]) * 25'(8'd255 - pipe_ff[2].ta)
                           + 25'(pipe_ff[2].tcta[i]) * 25'd255;
      end
      pipe_in[3].q = '0;
   end

   // stages 4..11: restoring divider, quotient never exceeds 255
   for (genvar k = DIV_FIRST; k < DIV_FIRST + DIV_BITS; k++) begin : g_div
      localparam int BIT = DIV_FIRST + DIV_BITS - 1 - k;
      always_comb begin
         logic [24:0] dsh;
         dsh = 25'(pipe_ff[k-1].den) << BIT;
         pipe_in[k] = pipe_ff[k-1];
         for (int i = 0; i < 3; i++) begin
            if (pipe_ff[k-1].rem[i] >= dsh) begin
               pipe_in[k].rem[i]    = pipe_ff[k-1].rem[i] - dsh;
               pipe_in[k].q[i][BIT] = 1'b1;
            end
         end
      end
   end

   // stage 12: pick alpha and colour per mode
   always_comb begin
      pipe_in[12] = pipe_ff[11];
      case (pipe_ff[11].mode)
         MODE_TINT: begin
            pipe_in[12].fa = pipe_ff[11].a;
            pipe_in[12].fc = pipe_ff[11].tmix;
         end
         MODE_DOUBLE: begin
            pipe_in[12].fa = pipe_ff[11].m;
            // zero divisor gives a zero channel
            pipe_in[12].fc = (pipe_ff[11].den == 17'd0) ? '0 : pipe_ff[11].q;
         end
         default: begin
            pipe_in[12].fa = pipe_ff[11].a;
            pipe_in[12].fc = pipe_ff[11].c;
         end
      endcase
   end

   // stage 13: over-blend onto the background; channel 0 is red in bits 23:16
   always_comb begin
      logic [15:0] sum;
      pipe_in[13] = pipe_ff[12];
      pipe_in[13].res[31:24] = pipe_ff[12].bg[31:24];
      for (int i = 0; i < 3; i++) begin
         sum = 16'(pipe_ff[12].bg[8*(2-i) +: 8]) * 16'(8'd255 - pipe_ff[12].fa)
             + 16'(pipe_ff[12].fc[i]) * 16'(pipe_ff[12].fa);
         pipe_in[13].res[8*(2-i) +: 8] = sum[15:8];
      end
      if (pipe_ff[12].mode == MODE_COPY) begin
         pipe_in[13].res = pipe_ff[12].img;
      end
   end

   // merged alpha never falls below either input alpha
   a_merge_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (pipe_ff[2].m >= pipe_ff[2].a) && (pipe_ff[2].m >= pipe_ff[2].ta))
      else $error("merged alpha below an input alpha");

   // a zero divisor drives every quotient bit high before the override
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[11] && pipe_ff[11].den == 17'd0) |-> (pipe_ff[11].q == {3{8'hff}}))
      else $error("divider misbehaves on a zero divisor");

   // a full stage that is held keeps its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[12] && !en[12]) |=> (valid_ff[12] && $stable(pipe_ff[12])))
      else $error("held stage lost its request");

endmodule

>>> dv/testbench.sv
// Testbench for the alpha blend pixel engine: drives random and directed pixel
// requests, predicts each composited pixel and checks it. Depends on abpe_pkg.
`timescale 1ns / 1ps

class blend_scoreboard;
   logic [1:0]  mode;
   logic        order;
   logic [31:0] tint;
   logic [31:0] pending[$];
   int          errors;

   function new();
      mode = abpe_pkg::MODE_COPY;
      order = 1'b0;
      tint = '0;
      errors = 0;
   endfunction

   function logic [7:0] over_ch(int unsigned bg, int unsigned fg, int unsigned a);
      return 8'((bg * (255 - a) + fg * a) >> 8);
   endfunction

   function logic [7:0] div_ch(int unsigned ta, int unsigned tc, int unsigned m,
                               int unsigned c);
      longint unsigned num;
      longint unsigned den;
      num = longint'(c) * m * (255 - ta) + 255 * tc * ta;
      den = 255 * (m + ta) - m * ta;
      if (den == 0) return 8'd0;
      return 8'(num / den);
   endfunction

   function void note_request(logic [31:0] img, logic [31:0] bg);
      int unsigned a, ta, ch[3], tc[3];
      logic [31:0] res;
      ta = tint[31:24];
      tc[0] = tint[23:16]; tc[1] = tint[15:8]; tc[2] = tint[7:0];
      if (order == 1'b0) begin
         ch[0] = img[7:0]; ch[1] = img[15:8]; ch[2] = img[23:16]; a = img[31:24];
      end else begin
         a = img[7:0]; ch[0] = img[15:8]; ch[1] = img[23:16]; ch[2] = img[31:24];
      end
      if (mode == abpe_pkg::MODE_COPY) begin
         pending.push_back(img);
         return;
      end
      if (mode == abpe_pkg::MODE_TINT) begin
         for (int i = 0; i < 3; i++) ch[i] = 8'((ch[i] * (255 - ta) + tc[i] * ta) >> 8);
      end else if (mode == abpe_pkg::MODE_DOUBLE) begin
         a = 8'(a + ta - (a * ta) / 255);
         for (int i = 0; i < 3; i++) ch[i] = div_ch(ta, tc[i], a, ch[i]);
      end
      res = {bg[31:24], over_ch(bg[23:16], ch[0], a), over_ch(bg[15:8], ch[1], a),
             over_ch(bg[7:0], ch[2], a)};
      pending.push_back(res);
   endfunction

   function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result %h", got);
         return;
      end
      want = pending.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) $display("result_pixel mismatch: expected %h, got %h", want, got);
      end
   endfunction
endclass

module testbench;
   import abpe_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   blend_scoreboard sb;
   int unsigned cycles;
   bit          hold_off;

   alpha_blend_pixel_engine_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // receiver: own stall pattern, plus a long hold-off on request
   initial begin
      int unsigned n;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         n = $urandom_range(0, 15);
         if (hold_off) rsp_tready <= 1'b0;
         else if (n < 5) rsp_tready <= 1'b0;
         else rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_BLEND_MODE) sb.mode = val[1:0];
      else if (idx == REG_CHANNEL_ORDER) sb.order = val[0];
      else if (idx == REG_TINT_ARGB) sb.tint = val;
   endtask

   task automatic send_pixel(logic [31:0] img, logic [31:0] bg);
      req_tvalid <= 1'b1;
      req_tdata <= {bg, img};
      do @(posedge clock); while (!req_tready);
      sb.note_request(img, bg);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return {$urandom_range(0, 1) ? 8'hff : 8'h00, 24'($urandom)};
         3: return {24'($urandom), $urandom_range(0, 1) ? 8'hff : 8'h00};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_burst(int count);
      int left;
      left = count;
      while (left > 0) begin
         for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
            send_pixel(pick_word(), pick_word());
            left--;
         end
         if ($urandom_range(0, 2) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   initial begin
      logic [31:0] tints[6];
      sb = new();
      hold_off = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_BLEND_MODE;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes in every mode and in both channel orders
      tints = '{32'h0, 32'hffff_ffff, 32'h00ff_8001, 32'hff00_0000, 32'h80_40c0ff, 32'h01_020304};
      for (int m = 0; m < 4; m++) begin
         write_reg(REG_BLEND_MODE, 32'(m));
         write_reg(REG_CHANNEL_ORDER, 32'(m[0]));
         write_reg(REG_TINT_ARGB, tints[m]);
         send_pixel(32'h0, 32'h0);          // all-zero image and background
         send_pixel(32'hffff_ffff, 32'h0);
         send_pixel(32'h0, 32'hffff_ffff);
         send_pixel(32'h80ff_00ff, 32'h7f00_ff00);
         send_pixel(32'h0000_00ff, 32'h1234_5678);
         wait_drained();
      end

      // random phases over register settings
      for (int p = 0; p < 18; p++) begin
         write_reg(REG_BLEND_MODE, 32'(p % 4));
         write_reg(REG_CHANNEL_ORDER, 32'((p / 4) % 2));
         write_reg(REG_TINT_ARGB, (p < 6) ? tints[p] : pick_word());
         if (p == 5) begin
            // long receiver hold-off while requests keep coming
            fork
               begin
                  hold_off = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_off = 1'b0;
               end
               random_burst(100);
            join
         end else begin
            random_burst(100);
         end
         wait_drained();
      end

      if (sb.errors == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule

>>> files.f
src/abpe_pkg.sv
src/alpha_blend_pixel_engine_top.sv
dv/testbench.sv
